// ===== rtl/core/dpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpc_pkg: shared types and constants of the resolution preset cycler
// Item formats, operation, status and register codes, and the request and
// response bundles of the serial remainder unit.
// ----------------------------------------------------------------------------
package dpc_pkg;

  localparam int unsigned DpiW       = 16;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 64;
  localparam int unsigned CountW     = 4;
  // The two ring words hold at most eight entries
  localparam int unsigned CuratedMax = 8;
  localparam int unsigned RingMaxDef = 8;
  localparam logic [DpiW-1:0] StepReset = 16'd50;

  // Operation codes
  localparam logic [1:0] OpCycle  = 2'd0;
  localparam logic [1:0] OpSet    = 2'd1;
  localparam logic [1:0] OpRecord = 2'd2;
  localparam logic [1:0] OpNone   = 2'd3;

  // Status codes
  localparam logic [1:0] StApplied = 2'd0;
  localparam logic [1:0] StNoConn  = 2'd1;
  localparam logic [1:0] StNoDesc  = 2'd2;
  localparam logic [1:0] StNoRing  = 2'd3;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegMinDpi    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegMaxDpi    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegDpiStep   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegAdjust    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegCurCount  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegRingLow   = 3'd5;
  localparam logic [CfgIdxW-1:0] RegRingHigh  = 3'd6;

  typedef struct packed {
    logic [1:0]      operation;
    logic [DpiW-1:0] requested_dpi;
    logic            connected;
    logic            descriptor_known;
  } in_item_t;

  typedef struct packed {
    logic [DpiW-1:0] new_dpi;
    logic            dpi_changed;
    logic [1:0]      status;
  } out_item_t;

  typedef struct packed {
    logic            start;
    logic [DpiW-1:0] dividend;
    logic [DpiW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DpiW-1:0] remainder;
  } div_rsp_t;

endpackage

// ===== rtl/core/dpc_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpc_div: serial remainder unit
// Restoring division, one dividend bit per cycle; returns the remainder with
// a done pulse in the cycle after the last step.
// ----------------------------------------------------------------------------
module dpc_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dpc_pkg::div_req_t req_i,
  output dpc_pkg::div_rsp_t rsp_o
);

  localparam int unsigned W    = dpc_pkg::DpiW;
  localparam int unsigned CntW = $clog2(W + 1);

  logic [W-1:0]    rem_q, rem_d;
  logic [W-1:0]    dvd_q, dvd_d;
  logic [W-1:0]    dvs_q, dvs_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            done_q, done_d;

  logic [W:0] shifted;
  logic [W:0] diff;

  // One restoring step; a clear top bit of diff means no borrow
  always_comb begin
    shifted = {rem_q, dvd_q[W-1]};
    diff    = shifted - {1'b0, dvs_q};
    rem_d   = rem_q;
    dvd_d   = dvd_q;
    dvs_d   = dvs_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    if (req_i.start) begin
      rem_d = '0;
      dvd_d = req_i.dividend;
      dvs_d = req_i.divisor;
      cnt_d = CntW'(W);
    end else if (cnt_q != '0) begin
      rem_d  = !diff[W] ? diff[W-1:0] : shifted[W-1:0];
      dvd_d  = {dvd_q[W-2:0], 1'b0};
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.remainder = rem_q;

  // Remainder is always below a nonzero divisor
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && (dvs_q != '0) |-> rem_q < dvs_q)
    else $error("remainder not below divisor");

  // Done only follows a running step
  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(cnt_q) == CntW'(1))
    else $error("done without final step");

  // A start always launches the full step count
  a_start_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |=> cnt_q == CntW'(W))
    else $error("start did not load step count");

endmodule

// ===== rtl/core/dpi_preset_cycler_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpi_preset_cycler_core: sensor resolution preset cycler
// Holds the current resolution, steps it through a preset ring on a cycle
// request, quantises set requests and stores device-reported values.
// ----------------------------------------------------------------------------
// One item is worked at a time; in_stall_o stays high until its result is
// loaded into the output register. A record, an unused code or a refused
// request goes straight to the result state. A set is rounded down to the
// step by the 16-step serial remainder unit (skipped with a zero step). A
// cycle request walks the ring one entry per cycle through a single distance
// compare, then quantises the chosen entry. With an empty curated ring the
// two- or three-entry derived ring is used, whose midpoint needs one more
// pass through the same remainder unit. The output register frees the
// input side: the next item is taken while the last result still waits.
module dpi_preset_cycler_core #(
  parameter int unsigned RING_MAX = dpc_pkg::RingMaxDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [dpc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [dpc_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  dpc_pkg::in_item_t              in_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output dpc_pkg::out_item_t             out_o
);

  localparam int unsigned W    = dpc_pkg::DpiW;
  // Holds a ring size up to RING_MAX, and the derived ring size of three
  localparam int unsigned CntW = (RING_MAX > 3) ? $clog2(RING_MAX + 1) : 2;

  typedef enum logic [2:0] {
    S_IDLE, S_MID, S_SEARCH, S_PICK, S_QUANT, S_QDIV, S_RESULT
  } state_e;

  // Configuration registers
  logic [W-1:0]                 min_q, max_q, step_q;
  logic                         adj_q;
  logic [dpc_pkg::CountW-1:0]   ccount_q;
  logic [dpc_pkg::CfgDataW-1:0] ring_lo_q, ring_hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q     <= '0;
      max_q     <= '0;
      step_q    <= dpc_pkg::StepReset;
      adj_q     <= 1'b0;
      ccount_q  <= '0;
      ring_lo_q <= '0;
      ring_hi_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dpc_pkg::RegMinDpi:   min_q     <= cfg_data_i[W-1:0];
        dpc_pkg::RegMaxDpi:   max_q     <= cfg_data_i[W-1:0];
        dpc_pkg::RegDpiStep:  step_q    <= cfg_data_i[W-1:0];
        dpc_pkg::RegAdjust:   adj_q     <= cfg_data_i[0];
        dpc_pkg::RegCurCount: ccount_q  <= cfg_data_i[dpc_pkg::CountW-1:0];
        dpc_pkg::RegRingLow:  ring_lo_q <= cfg_data_i;
        dpc_pkg::RegRingHigh: ring_hi_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Curated entries as an array
  logic [W-1:0] curated [dpc_pkg::CuratedMax];
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      curated[k]     = ring_lo_q[k*W +: W];
      curated[k + 4] = ring_hi_q[k*W +: W];
    end
  end

  // Curated count limited to the ring size
  logic [CntW-1:0] ccount_lim;
  assign ccount_lim = (int'(ccount_q) > int'(RING_MAX)) ? CntW'(RING_MAX)
                                                        : CntW'(ccount_q);

  // Sequencer state
  state_e             state_q;
  logic [CntW-1:0]    ring_n_q;
  logic               use_cur_q;
  logic               ring3_q;
  logic [CntW-1:0]    idx_q;
  logic [CntW-1:0]    near_q;
  logic [W-1:0]       best_q;
  logic [W-1:0]       mid_q;
  logic [W-1:0]       work_q;
  logic [W-1:0]       res_q;
  logic [1:0]         stat_q;
  logic [W-1:0]       cur_q;
  logic               out_valid_q;
  dpc_pkg::out_item_t out_q;

  dpc_pkg::div_req_t div_req;
  dpc_pkg::div_rsp_t div_rsp;

  // Ring entry read, one port
  logic [CntW-1:0] nxt_idx;
  logic [CntW-1:0] sel_idx;
  logic [W-1:0]    entry;

  assign nxt_idx = (near_q + 1'b1 >= ring_n_q) ? '0 : near_q + 1'b1;
  assign sel_idx = (state_q == S_PICK) ? nxt_idx : idx_q;

  always_comb begin
    if (use_cur_q) begin
      entry = curated[3'(sel_idx)];
    end else if (sel_idx == '0) begin
      entry = min_q;
    end else if (sel_idx == CntW'(1) && ring3_q) begin
      entry = mid_q;
    end else begin
      entry = max_q;
    end
  end

  // Shared distance compare
  logic [W-1:0] delta;
  assign delta = (entry > cur_q) ? entry - cur_q : cur_q - entry;

  // Midpoint offset from min, clamped value for quantising
  logic [W:0]   mid_sum;
  logic [W-1:0] mid_off;
  logic [W-1:0] clamped;
  logic [W:0]   mid_full;
  logic         no_derived;

  assign mid_sum    = {1'b0, min_q} + {1'b0, max_q};
  assign mid_off    = mid_sum[W:1] - min_q;
  assign mid_full   = {1'b0, min_q} + {1'b0, mid_off} - {1'b0, div_rsp.remainder};
  assign no_derived = !adj_q || (max_q <= min_q) || (step_q == '0);

  always_comb begin
    clamped = (work_q > max_q) ? max_q : work_q;
    clamped = (clamped < min_q) ? min_q : clamped;
  end

  logic slot_free;
  assign slot_free = !out_valid_q || !out_stall_i;

  // Remainder unit requests
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = clamped;
    div_req.divisor  = step_q;
    if (state_q == S_IDLE) begin
      div_req.dividend = mid_off;
      div_req.start    = in_valid_i && (in_i.operation == dpc_pkg::OpCycle)
                         && in_i.connected && in_i.descriptor_known
                         && (ccount_lim == '0) && !no_derived;
    end else if (state_q == S_QUANT) begin
      div_req.start = (step_q != '0);
    end
  end

  dpc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Sequencer, current value and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
      ring_n_q    <= '0;
      use_cur_q   <= 1'b0;
      ring3_q     <= 1'b0;
      idx_q       <= '0;
      near_q      <= '0;
      best_q      <= '0;
      mid_q       <= '0;
      work_q      <= '0;
      res_q       <= '0;
      stat_q      <= dpc_pkg::StApplied;
      out_q       <= '0;
    end else begin
      // Output valid: set on a loaded result, cleared once taken
      if ((state_q == S_RESULT) && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            work_q <= in_i.requested_dpi;
            case (in_i.operation)
              dpc_pkg::OpCycle: begin
                res_q <= cur_q;
                if (!in_i.connected) begin
                  stat_q  <= dpc_pkg::StNoConn;
                  state_q <= S_RESULT;
                end else if (!in_i.descriptor_known) begin
                  stat_q  <= dpc_pkg::StNoDesc;
                  state_q <= S_RESULT;
                end else if (ccount_lim != '0) begin
                  stat_q    <= dpc_pkg::StApplied;
                  ring_n_q  <= ccount_lim;
                  use_cur_q <= 1'b1;
                  idx_q     <= '0;
                  state_q   <= S_SEARCH;
                end else if (no_derived) begin
                  stat_q  <= dpc_pkg::StNoRing;
                  state_q <= S_RESULT;
                end else begin
                  stat_q    <= dpc_pkg::StApplied;
                  use_cur_q <= 1'b0;
                  state_q   <= S_MID;
                end
              end
              dpc_pkg::OpSet: begin
                res_q <= cur_q;
                if (!in_i.connected) begin
                  stat_q  <= dpc_pkg::StNoConn;
                  state_q <= S_RESULT;
                end else begin
                  stat_q  <= dpc_pkg::StApplied;
                  state_q <= S_QUANT;
                end
              end
              dpc_pkg::OpRecord: begin
                res_q   <= in_i.requested_dpi;
                stat_q  <= dpc_pkg::StApplied;
                state_q <= S_RESULT;
              end
              default: begin
                res_q   <= cur_q;
                stat_q  <= dpc_pkg::StApplied;
                state_q <= S_RESULT;
              end
            endcase
          end
        end
        S_MID: begin
          if (div_rsp.done) begin
            mid_q    <= mid_full[W-1:0];
            ring3_q  <= (mid_full[W-1:0] > min_q) && (mid_full[W-1:0] < max_q);
            ring_n_q <= ((mid_full[W-1:0] > min_q) && (mid_full[W-1:0] < max_q))
                        ? CntW'(3) : CntW'(2);
            idx_q    <= '0;
            state_q  <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (idx_q == '0 || delta < best_q) begin
            best_q <= delta;
            near_q <= idx_q;
          end
          if (idx_q == ring_n_q - 1'b1) begin
            state_q <= S_PICK;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_PICK: begin
          work_q  <= entry;
          state_q <= S_QUANT;
        end
        S_QUANT: begin
          work_q <= clamped;
          if (step_q == '0) begin
            res_q   <= clamped;
            state_q <= S_RESULT;
          end else begin
            state_q <= S_QDIV;
          end
        end
        S_QDIV: begin
          if (div_rsp.done) begin
            res_q   <= work_q - div_rsp.remainder;
            state_q <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (slot_free) begin
            out_q.new_dpi     <= res_q;
            out_q.dpi_changed <= (res_q != cur_q);
            out_q.status      <= stat_q;
            cur_q             <= res_q;
            state_q           <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // Remainder results arrive only while the sequencer waits for them
  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_MID) || (state_q == S_QDIV))
    else $error("remainder result outside a wait state");

  // Ring walk stays inside the ring
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEARCH) |-> (idx_q < ring_n_q) && (ring_n_q != '0))
    else $error("ring index out of range");

  // A loaded result reports the new current value
  a_res_cur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESULT) && slot_free |=> out_valid_q && (out_q.new_dpi == cur_q))
    else $error("result does not match current value");

  // Taking an item makes the block busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("block not busy after taking an item");

endmodule
